@@ rtl/srtt_pkg.sv @@
// Shared types and constants for the serial read terminator/timeout block.
package srtt_pkg;

	localparam int unsigned TERM_W = 56;
	localparam int unsigned CNT_W  = 16;
	localparam logic [CNT_W-1:0] CHAR_TO_RST = 16'd100;

	typedef enum logic [1:0] {
		FN_START = 2'd0,
		FN_BYTE  = 2'd1,
		FN_TICK  = 2'd2,
		FN_FLUSH = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_RUN     = 3'd0,
		ST_LEN     = 3'd1,
		ST_TERM    = 3'd2,
		ST_REPLY_TO = 3'd3,
		ST_CHAR_TO = 3'd4
	} end_status_t;

	typedef enum logic [1:0] {
		REG_TERM_BYTES = 2'd0,
		REG_TERM_LEN   = 2'd1,
		REG_CHAR_TO    = 2'd2,
		REG_NONE       = 2'd3
	} cfg_reg_t;

	// controller -> datapath
	typedef struct packed {
		logic        load;
		logic        start;
		logic        tick;
		logic        push;
		logic        flush;
		logic        pop;
		logic        deliver;
		logic        deliver_live;
		logic        emit;
		end_status_t emit_code;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		func_t func;
		logic  zero_len;
		logic  active;
		logic  got_first;
		logic  fifo_nonempty;
		logic  first_to_zero;
		logic  out_free;
	} stat_t;

endpackage

@@ rtl/srtt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module srtt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/srtt_ctrl.sv @@
// Sequencer for the serial read block: decodes items and walks the FIFO drain.
module srtt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  srtt_pkg::stat_t stat,
	output srtt_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DRAIN_CHK,
		S_DRAIN_DLV
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd          = '0;
		cmd.emit_code = srtt_pkg::ST_RUN;
		state_d      = state_q;
		in_ready     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (stat.func)
					srtt_pkg::FN_START: begin
						cmd.start = 1'b1;
						state_d   = S_DRAIN_CHK;
					end
					srtt_pkg::FN_BYTE: begin
						if (!stat.active) begin
							cmd.push = 1'b1;
							state_d  = S_IDLE;
						end else if (stat.out_free) begin
							cmd.deliver      = 1'b1;
							cmd.deliver_live = 1'b1;
							state_d          = S_IDLE;
						end
					end
					srtt_pkg::FN_TICK: begin
						// hold the tick until a possible result has room
						if (!stat.active || stat.out_free) begin
							cmd.tick = 1'b1;
							state_d  = S_IDLE;
						end
					end
					srtt_pkg::FN_FLUSH: begin
						cmd.flush = 1'b1;
						state_d   = S_IDLE;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_DRAIN_CHK: begin
				priority if (stat.zero_len) begin
					if (stat.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_code = srtt_pkg::ST_LEN;
						state_d       = S_IDLE;
					end
				end else if (stat.active && stat.fifo_nonempty) begin
					cmd.pop = 1'b1;
					state_d = S_DRAIN_DLV;
				end else if (stat.active && !stat.got_first && stat.first_to_zero) begin
					if (stat.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_code = srtt_pkg::ST_REPLY_TO;
						state_d       = S_IDLE;
					end
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DRAIN_DLV: begin
				if (stat.out_free) begin
					cmd.deliver = 1'b1;
					state_d     = S_DRAIN_CHK;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/srtt_dp.sv @@
// Datapath: config registers, FIFO pointers and RAM, read state, result register.
module srtt_dp #(
	parameter int unsigned FIFO_DEPTH = 32,
	parameter int unsigned TERM_MAX   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  func,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] req_len,
	input  logic [15:0] reply_timeout_ms,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [55:0] cfg_data,
	input  srtt_pkg::cmd_t cmd,
	output srtt_pkg::stat_t stat,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        done_res,
	output logic [2:0]  end_status,
	output logic [15:0] read_count
);

	localparam int unsigned AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned FW = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned TW = srtt_pkg::TERM_W;
	localparam int unsigned CW = srtt_pkg::CNT_W;

	// configuration
	logic [TW-1:0] term_bytes_q;
	logic [2:0]    term_len_q;
	logic [CW-1:0] char_to_q;

	// latched item
	srtt_pkg::func_t func_q;
	logic [7:0]    byte_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] rto_q;

	// FIFO
	logic [AW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic [FW:0]   waddr_sum;
	logic [AW-1:0] waddr;
	logic [AW-1:0] head_inc;
	logic [7:0]    ram_rdata;
	logic          fifo_we;

	// read state
	logic          active_q;
	logic          got_first_q;
	logic [CW-1:0] left_q;
	logic [CW-1:0] done_q;
	logic [CW-1:0] ticks_q;
	logic [CW-1:0] first_to_q;
	logic [TW-1:0] hist_q;

	// result register
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          byte_valid_q;
	logic          done_res_q;
	srtt_pkg::end_status_t end_status_q;
	logic [CW-1:0] read_count_q;

	// deliver path
	logic [7:0]    dlv_byte;
	logic [CW-1:0] done_nx;
	logic [CW-1:0] left_nx;
	logic [TW-1:0] hist_nx;
	logic [TW-1:0] term_mask;
	logic          term_hit;
	srtt_pkg::end_status_t dlv_code;

	// tick path
	logic [CW-1:0] ticks_nx;
	logic [CW-1:0] limit;
	logic          expire;
	logic          out_free;

	// ring address of the next free slot
	assign waddr_sum = (FW + 1)'(head_q) + (FW + 1)'(fill_q);
	assign waddr = (waddr_sum >= (FW + 1)'(FIFO_DEPTH)) ?
		AW'(waddr_sum - (FW + 1)'(FIFO_DEPTH)) : AW'(waddr_sum);
	assign head_inc = (head_q == AW'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign fifo_we = cmd.push && (fill_q < FW'(FIFO_DEPTH));

	srtt_ram #(
		.WIDTH(8),
		.DEPTH(FIFO_DEPTH)
	) u_fifo_ram (
		.clk  (clk),
		.we   (fifo_we),
		.waddr(waddr),
		.wdata(byte_q),
		.re   (cmd.pop),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		for (int i = 0; i < TW / 8; i++) begin
			term_mask[i*8 +: 8] = (i < int'(term_len_q)) ? 8'hFF : 8'h00;
		end
	end

	assign dlv_byte = cmd.deliver_live ? byte_q : ram_rdata;
	assign done_nx  = done_q + 1'b1;
	assign left_nx  = left_q - 1'b1;
	assign hist_nx  = {hist_q[TW-9:0], dlv_byte};
	assign term_hit = (term_len_q != 3'd0) && (4'(term_len_q) < 4'(TERM_MAX))
		&& (done_nx >= CW'(term_len_q))
		&& ((hist_nx & term_mask) == (term_bytes_q & term_mask));
	assign dlv_code = term_hit ? srtt_pkg::ST_TERM :
		((left_nx == '0) ? srtt_pkg::ST_LEN : srtt_pkg::ST_RUN);

	assign ticks_nx = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;
	assign limit    = got_first_q ? char_to_q : first_to_q;
	assign expire   = ticks_nx >= limit;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		stat.func          = func_q;
		stat.zero_len      = (len_q == '0);
		stat.active        = active_q;
		stat.got_first     = got_first_q;
		stat.fifo_nonempty = (fill_q != '0);
		stat.first_to_zero = (first_to_q == '0);
		stat.out_free      = out_free;
	end

	// payload-only registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= srtt_pkg::func_t'(func);
			byte_q <= rx_byte;
			len_q  <= req_len;
			rto_q  <= reply_timeout_ms;
		end
		priority if (cmd.deliver) begin
			out_byte_q   <= dlv_byte;
			byte_valid_q <= 1'b1;
			done_res_q   <= (dlv_code != srtt_pkg::ST_RUN);
			end_status_q <= dlv_code;
			read_count_q <= done_nx;
		end else if (cmd.emit) begin
			out_byte_q   <= '0;
			byte_valid_q <= 1'b0;
			done_res_q   <= 1'b1;
			end_status_q <= cmd.emit_code;
			read_count_q <= done_q;
		end else if (cmd.tick && active_q) begin
			out_byte_q   <= '0;
			byte_valid_q <= 1'b0;
			done_res_q   <= 1'b1;
			end_status_q <= got_first_q ? srtt_pkg::ST_CHAR_TO : srtt_pkg::ST_REPLY_TO;
			read_count_q <= done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_bytes_q <= '0;
			term_len_q   <= '0;
			char_to_q    <= srtt_pkg::CHAR_TO_RST;
			head_q       <= '0;
			fill_q       <= '0;
			active_q     <= 1'b0;
			got_first_q  <= 1'b0;
			left_q       <= '0;
			done_q       <= '0;
			ticks_q      <= '0;
			first_to_q   <= '0;
			hist_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (srtt_pkg::cfg_reg_t'(cfg_index))
					srtt_pkg::REG_TERM_BYTES: term_bytes_q <= cfg_data;
					srtt_pkg::REG_TERM_LEN:   term_len_q   <= cfg_data[2:0];
					srtt_pkg::REG_CHAR_TO:    char_to_q    <= cfg_data[CW-1:0];
					default: ;
				endcase
			end

			priority if (cmd.flush) begin
				head_q <= '0;
				fill_q <= '0;
			end else if (fifo_we) begin
				fill_q <= fill_q + 1'b1;
			end else if (cmd.pop) begin
				head_q <= head_inc;
				fill_q <= fill_q - 1'b1;
			end

			priority if (cmd.start) begin
				active_q    <= (len_q != '0);
				got_first_q <= 1'b0;
				left_q      <= len_q;
				done_q      <= '0;
				ticks_q     <= '0;
				first_to_q  <= rto_q;
				hist_q      <= '0;
			end else if (cmd.deliver) begin
				done_q      <= done_nx;
				left_q      <= left_nx;
				got_first_q <= 1'b1;
				ticks_q     <= '0;
				hist_q      <= hist_nx;
				if (dlv_code != srtt_pkg::ST_RUN) begin
					active_q <= 1'b0;
				end
			end else if (cmd.emit) begin
				active_q <= 1'b0;
			end else if (cmd.tick && active_q) begin
				ticks_q <= ticks_nx;
				if (expire) begin
					active_q <= 1'b0;
				end
			end

			if (cmd.deliver || cmd.emit || (cmd.tick && active_q && expire)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign done_res   = done_res_q;
	assign end_status = end_status_q;
	assign read_count = read_count_q;

endmodule

@@ rtl/serial_read_terminator_timeout.sv @@
// Top level of the serial read block with terminator and character timeout.
//
// Input channel (in_valid/in_ready) carries one command item: func selects
// start read, received byte, millisecond tick or FIFO flush. Output channel
// (out_valid/out_ready) carries one result item per delivered byte, plus one
// item when a read ends without a byte (zero length, reply or char timeout).
// Received bytes are buffered in a FIFO_DEPTH-entry RAM while no read runs;
// bytes arriving into a full FIFO are dropped. A start drains the FIFO one
// byte at a time (RAM read, then delivery), then live bytes pass straight
// through. Terminator is compared against the last term_len bytes after each
// delivered byte; term_len of TERM_MAX or more disables it.
// A byte or tick result is registered once its item has been latched and the
// output register has room; buffered bytes are read through the single RAM
// read port. Items are taken one at a time, since in_ready is high
// only in the idle state. Results sit in one output register; while it is
// full and not taken, any step that would produce a result waits, so a
// stalled receiver holds the block without losing anything.
// Reset: FIFO empty, no read running, terminator cleared, char timeout 100.
// Config writes (cfg_we/cfg_index/cfg_data) take effect the next cycle and
// are to be issued while the block is idle.
module serial_read_terminator_timeout #(
	parameter int unsigned FIFO_DEPTH = 32,
	parameter int unsigned TERM_MAX   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// command items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] req_len,
	input  logic [15:0] reply_timeout_ms,
	// result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        done_res,
	output logic [2:0]  end_status,
	output logic [15:0] read_count,
	// register writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [55:0] cfg_data
);

	srtt_pkg::cmd_t  cmd;
	srtt_pkg::stat_t stat;

	// sequencer: accepts items, steps the drain loop, gates on output space
	srtt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// datapath: registers, FIFO RAM, terminator match, tick compare, output reg
	srtt_dp #(
		.FIFO_DEPTH(FIFO_DEPTH),
		.TERM_MAX  (TERM_MAX)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.func            (func),
		.rx_byte         (rx_byte),
		.req_len         (req_len),
		.reply_timeout_ms(reply_timeout_ms),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.stat            (stat),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_byte        (out_byte),
		.byte_valid      (byte_valid),
		.done_res        (done_res),
		.end_status      (end_status),
		.read_count      (read_count)
	);

endmodule
